// ===== sv/ptd_pkg.sv =====
package ptd_pkg;

	// opcodes of a request transaction
	localparam logic [1:0] OP_REG    = 2'd0;
	localparam logic [1:0] OP_ALL    = 2'd1;
	localparam logic [1:0] OP_BUDGET = 2'd2;

	// status codes of a result transaction
	localparam logic [1:0] ST_REGD = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;
	localparam logic [1:0] ST_NONE = 2'd3;

	localparam logic [47:0] TIME_MAX   = 48'hFFFF_FFFF_FFFF;
	localparam logic [6:0]  RESULT_CAP = 7'd64;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [47:0] now_ms;
		logic [31:0] interval_ms;
		logic [15:0] order_key;
		logic [6:0]  max_ops;
		logic        ordered_by_key;
	} req_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] task_slot;
		logic       last;
	} rsp_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic reg_write;
		logic rd;
		logic all_hit;
		logic eval;
		logic run;
		logic fin;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] op;
		logic       scan_done;
		logic       hit;
		logic       found;
		logic       pend_v;
		logic       out_free;
		logic       budget_last;
	} dp_sts_t;

endpackage

// ===== sv/periodic_task_dispatcher.sv =====
// Sequence: a registration goes through S_REG, which loads its result into the output
// register once that is free; a poll-all reads and checks each table slot (S_RD, S_EV), then
// finishes in S_FIN; a budgeted poll rescans the table before each task run (S_RUN) and
// finishes in S_FIN. Throughput: one request transaction at a time; the next is taken once
// the last result is loaded into the output register. The scan reads one slot at a time
// from the tables, and a held result stalls the scan while the output register is occupied.
// Reset: arst_n clears the task count, controller state and valid flags; table contents
// are left as they are and are written before they are ever read.
module periodic_task_dispatcher #(
	parameter int MAX_TASKS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  ptd_pkg::req_item_t  req_data,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output ptd_pkg::rsp_item_t  rsp_data
);
	import ptd_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	ptd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_opcode (req_data.opcode),
		.sts        (sts),
		.cmd        (cmd)
	);

	ptd_datapath #(
		.MAX_TASKS (MAX_TASKS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	// no held run result may survive into idle
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !sts.pend_v)
		else $error("held run result left over at idle");

	// full and nothing-due results are single, final and carry slot zero
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp_data.status == ST_FULL || rsp_data.status == ST_NONE))
		|-> (rsp_data.last && rsp_data.task_slot == 4'd0))
		else $error("full or nothing-due result malformed");

	// a registration transaction is never followed by an immediate accept
	a_reg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && req_data.opcode == OP_REG) |=> !req_ready)
		else $error("accepted a request before registration result");

	// a registration result is always the final one of its transaction
	a_reg_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.status == ST_REGD) |-> rsp_data.last)
		else $error("registration result not final");

endmodule

// ===== sv/ptd_datapath.sv =====
module ptd_datapath #(
	parameter int MAX_TASKS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ptd_pkg::req_item_t  req_data,
	input  ptd_pkg::dp_cmd_t    cmd,
	output ptd_pkg::dp_sts_t    sts,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output ptd_pkg::rsp_item_t  rsp_data
);
	import ptd_pkg::*;

	localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W  = $clog2(MAX_TASKS + 1);

	// captured request
	logic [1:0]  op_q;
	logic [47:0] now_q;
	logic [31:0] interval_q;
	logic [15:0] key_q;
	logic        by_key_q;
	logic [6:0]  budget_q;
	logic [6:0]  n_q;

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	logic [SLOT_W-1:0] rd_slot_q;

	// task tables
	logic [31:0] period_mem [MAX_TASKS];
	logic [47:0] due_mem    [MAX_TASKS];
	logic [15:0] key_mem    [MAX_TASKS];

	logic [31:0] rd_period_q;
	logic [47:0] rd_due_q;
	logic [15:0] rd_key_q;

	// best pick of a budgeted scan
	logic              found_q;
	logic [SLOT_W-1:0] pick_slot_q;
	logic [15:0]       pick_key_q;
	logic [31:0]       pick_period_q;

	// held run result and output register
	logic       pend_v_q;
	logic [3:0] pend_slot_q;
	logic       out_v_q;
	rsp_item_t  out_q;

	logic        full;
	logic        hit;
	logic        better;
	logic        out_free;
	logic [6:0]  budget_in;
	logic [31:0] adv_period;
	logic [48:0] next_sum;
	logic [47:0] next_due;
	logic        due_we;
	logic [SLOT_W-1:0] due_waddr;
	logic [47:0] due_wdata;
	logic        emit;
	rsp_item_t   emit_item;

	assign full     = (count_q == CNT_W'(MAX_TASKS));
	assign hit      = (now_q >= rd_due_q);
	assign better   = hit && (!found_q || (by_key_q && (rd_key_q < pick_key_q)));
	assign out_free = !out_v_q || rsp_ready;

	// clamp the run budget to one through the result cap
	always_comb begin
		budget_in = req_data.max_ops;
		if (req_data.max_ops == 7'd0) begin
			budget_in = 7'd1;
		end else if (req_data.max_ops > RESULT_CAP) begin
			budget_in = RESULT_CAP;
		end
	end

	// next due time, saturated
	assign adv_period = cmd.run ? pick_period_q : rd_period_q;
	assign next_sum   = {1'b0, now_q} + {17'd0, adv_period};
	assign next_due   = next_sum[48] ? TIME_MAX : next_sum[47:0];

	// select the due time write
	always_comb begin
		due_we    = (cmd.reg_write && !full) || cmd.all_hit || cmd.run;
		due_waddr = count_q[SLOT_W-1:0];
		due_wdata = now_q;
		if (cmd.run) begin
			due_waddr = pick_slot_q;
			due_wdata = next_due;
		end else if (cmd.all_hit) begin
			due_waddr = rd_slot_q;
			due_wdata = next_due;
		end
	end

	// write and read the tables
	always_ff @(posedge clk) begin
		if (cmd.reg_write && !full) begin
			period_mem[count_q[SLOT_W-1:0]] <= interval_q;
			key_mem[count_q[SLOT_W-1:0]]    <= key_q;
		end
		if (due_we) begin
			due_mem[due_waddr] <= due_wdata;
		end
		if (cmd.rd) begin
			rd_period_q <= period_mem[idx_q[SLOT_W-1:0]];
			rd_due_q    <= due_mem[idx_q[SLOT_W-1:0]];
			rd_key_q    <= key_mem[idx_q[SLOT_W-1:0]];
		end
	end

	// pick the result transaction to push out
	always_comb begin
		emit      = 1'b0;
		emit_item = '0;
		if (cmd.reg_write) begin
			emit = 1'b1;
			if (full) begin
				emit_item = '{status: ST_FULL, task_slot: 4'd0, last: 1'b1};
			end else begin
				emit_item = '{status: ST_REGD, task_slot: 4'(count_q), last: 1'b1};
			end
		end else if ((cmd.all_hit || cmd.run) && pend_v_q) begin
			emit      = 1'b1;
			emit_item = '{status: ST_RUN, task_slot: pend_slot_q, last: 1'b0};
		end else if (cmd.fin) begin
			emit = 1'b1;
			if (pend_v_q) begin
				emit_item = '{status: ST_RUN, task_slot: pend_slot_q, last: 1'b1};
			end else begin
				emit_item = '{status: ST_NONE, task_slot: 4'd0, last: 1'b1};
			end
		end
	end

	// capture the request, best-pick payload, read and held slots and the result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q       <= req_data.opcode;
			now_q      <= req_data.now_ms;
			interval_q <= req_data.interval_ms;
			key_q      <= req_data.order_key;
			by_key_q   <= req_data.ordered_by_key;
			budget_q   <= budget_in;
		end
		if (cmd.rd) begin
			rd_slot_q <= idx_q[SLOT_W-1:0];
		end
		if (cmd.eval && better) begin
			pick_slot_q   <= rd_slot_q;
			pick_key_q    <= rd_key_q;
			pick_period_q <= rd_period_q;
		end
		if (cmd.all_hit) begin
			pend_slot_q <= 4'(rd_slot_q);
		end else if (cmd.run) begin
			pend_slot_q <= 4'(pick_slot_q);
		end
		if (emit) begin
			out_q <= emit_item;
		end
	end

	// control state of the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			idx_q    <= '0;
			found_q  <= 1'b0;
			n_q      <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.load || cmd.run) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.rd) begin
					idx_q <= idx_q + CNT_W'(1);
				end
				if (cmd.eval && better) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.load) begin
				n_q <= '0;
			end else if (cmd.run) begin
				n_q <= n_q + 7'd1;
			end
			if (cmd.reg_write && !full) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.load || cmd.fin) begin
				pend_v_q <= 1'b0;
			end else if (cmd.all_hit || cmd.run) begin
				pend_v_q <= 1'b1;
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (rsp_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign sts.op          = op_q;
	assign sts.scan_done   = (idx_q == count_q);
	assign sts.hit         = hit;
	assign sts.found       = found_q;
	assign sts.pend_v      = pend_v_q;
	assign sts.out_free    = out_free;
	assign sts.budget_last = ((n_q + 7'd1) == budget_q);

	assign rsp_valid = out_v_q;
	assign rsp_data  = out_q;

endmodule

// ===== sv/ptd_ctrl.sv =====
module ptd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [1:0]        req_opcode,
	input  ptd_pkg::dp_sts_t  sts,
	output ptd_pkg::dp_cmd_t  cmd
);
	import ptd_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_REG,
		S_RD,
		S_EV,
		S_RUN,
		S_FIN
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// decode commands and next state
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		req_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					case (req_opcode)
						OP_REG:    state_nxt = S_REG;
						OP_ALL:    state_nxt = S_RD;
						OP_BUDGET: state_nxt = S_RD;
						default:   state_nxt = S_IDLE;
					endcase
				end
			end
			S_REG: begin
				if (sts.out_free) begin
					cmd.reg_write = 1'b1;
					state_nxt     = S_IDLE;
				end
			end
			S_RD: begin
				if (sts.scan_done) begin
					state_nxt = (sts.op == OP_ALL) ? S_FIN : S_RUN;
				end else begin
					cmd.rd    = 1'b1;
					state_nxt = S_EV;
				end
			end
			S_EV: begin
				if (sts.op == OP_ALL) begin
					if (!sts.hit) begin
						state_nxt = S_RD;
					end else if (!sts.pend_v || sts.out_free) begin
						cmd.all_hit = 1'b1;
						state_nxt   = S_RD;
					end
				end else begin
					cmd.eval  = 1'b1;
					state_nxt = S_RD;
				end
			end
			S_RUN: begin
				if (!sts.found) begin
					state_nxt = S_FIN;
				end else if (!sts.pend_v || sts.out_free) begin
					cmd.run   = 1'b1;
					state_nxt = sts.budget_last ? S_FIN : S_RD;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.fin   = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== tb/sv/periodic_task_dispatcher_tb.sv =====
module periodic_task_dispatcher_tb;
	import ptd_pkg::*;

	localparam int TASK_SLOTS = 16;
	localparam int CYCLE_LIMIT = 6_000_000;
	localparam int RANDOM_ITEMS = 400;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Track the task table and queue the results that each request transaction must produce
	class dispatch_scoreboard;
		logic [31:0] period_tab[TASK_SLOTS];
		logic [47:0] due_tab[TASK_SLOTS];
		logic [15:0] key_tab[TASK_SLOTS];
		int unsigned n_tasks = 0;
		rsp_item_t outcome_q[$];
		int errors = 0;

		task report(input string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		// Move a slot to now plus its period, clamped at the top of the time range
		function void reschedule(input int unsigned slot, input logic [47:0] now_ms);
			logic [48:0] sum;
			sum = {1'b0, now_ms} + {17'd0, period_tab[slot]};
			due_tab[slot] = sum[48] ? TIME_MAX : sum[47:0];
		endfunction

		function void push_outcome(input logic [1:0] status, input int unsigned slot,
				input logic last);
			rsp_item_t r;
			r.status = status;
			r.task_slot = slot[3:0];
			r.last = last;
			outcome_q = {outcome_q, r};
		endfunction

		function void note_request(input req_item_t rq);
			int unsigned runs;
			int unsigned budget;
			int unsigned pick;
			bit found;
			runs = 0;
			case (rq.opcode)
				OP_REG: begin
					if (n_tasks >= TASK_SLOTS) begin
						push_outcome(ST_FULL, 0, 1'b1);
					end else begin
						period_tab[n_tasks] = rq.interval_ms;
						due_tab[n_tasks] = rq.now_ms;
						key_tab[n_tasks] = rq.order_key;
						push_outcome(ST_REGD, n_tasks, 1'b1);
						n_tasks++;
					end
					return;
				end
				OP_ALL: begin
					for (int unsigned i = 0; i < n_tasks && runs < RESULT_CAP; i++) begin
						if (rq.now_ms >= due_tab[i]) begin
							push_outcome(ST_RUN, i, 1'b0);
							runs++;
							reschedule(i, rq.now_ms);
						end
					end
				end
				OP_BUDGET: begin
					budget = {25'd0, rq.max_ops};
					if (budget == 0)
						budget = 1;
					if (budget > RESULT_CAP)
						budget = RESULT_CAP;
					while (runs < budget) begin
						found = 1'b0;
						pick = 0;
						for (int unsigned i = 0; i < n_tasks; i++) begin
							if (rq.now_ms < due_tab[i])
								continue;
							if (!found || (rq.ordered_by_key && key_tab[i] < key_tab[pick])) begin
								pick = i;
								found = 1'b1;
								if (!rq.ordered_by_key)
									break;
							end
						end
						if (!found)
							break;
						push_outcome(ST_RUN, pick, 1'b0);
						runs++;
						reschedule(pick, rq.now_ms);
					end
				end
				default: return;
			endcase
			// Close the transaction: mark the final run, or report nothing due
			if (runs == 0)
				push_outcome(ST_NONE, 0, 1'b1);
			else
				outcome_q[outcome_q.size() - 1].last = 1'b1;
		endfunction

		task check_result(input rsp_item_t got);
			rsp_item_t want;
			if (outcome_q.size() == 0) begin
				report($sformatf("unexpected result status=%0d slot=%0d last=%0d",
					got.status, got.task_slot, got.last));
				return;
			end
			want = outcome_q.pop_front();
			if (got.status !== want.status)
				report($sformatf("status got %0d want %0d", got.status, want.status));
			if (got.task_slot !== want.task_slot)
				report($sformatf("task_slot got %0d want %0d", got.task_slot, want.task_slot));
			if (got.last !== want.last)
				report($sformatf("last got %0d want %0d", got.last, want.last));
		endtask
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_item_t req_data = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_item_t rsp_data;

	dispatch_scoreboard sb = new;
	int send_quiet = 0;
	int recv_quiet = 0;
	int results_seen = 0;
	int cycle_count = 0;

	periodic_task_dispatcher #(.MAX_TASKS(TASK_SLOTS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data(rsp_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic req_item_t make_req(input logic [1:0] op, input logic [47:0] now_ms,
			input logic [31:0] ival, input logic [15:0] key, input logic [6:0] max_ops,
			input logic by_key);
		req_item_t r;
		r.opcode = op;
		r.now_ms = now_ms;
		r.interval_ms = ival;
		r.order_key = key;
		r.max_ops = max_ops;
		r.ordered_by_key = by_key;
		return r;
	endfunction

	function automatic logic [47:0] rand_time();
		return {16'($urandom), $urandom};
	endfunction

	// Offer one request transaction after a random gap and hold it until accepted
	task automatic send_req(input req_item_t it);
		int gap;
		if (send_quiet > 0) begin
			gap = 0;
			send_quiet--;
		end else begin
			gap = $urandom_range(0, 16);
			if ($urandom_range(0, 24) == 0)
				send_quiet = $urandom_range(8, 30);
		end
		@(negedge clk);
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_data = it;
		req_valid = 1'b1;
		do @(posedge clk); while (!req_ready);
		sb.note_request(it);
	endtask

	// Accept results with random stalls, and hold off once for a long stretch
	initial begin
		int gap;
		bit held_off;
		held_off = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held_off && results_seen >= 150) begin
				held_off = 1'b1;
				@(negedge clk);
				rsp_ready = 1'b0;
				repeat (500) @(negedge clk);
			end
			if (recv_quiet > 0) begin
				gap = 0;
				recv_quiet--;
			end else begin
				gap = $urandom_range(0, 16);
				if ($urandom_range(0, 24) == 0)
					recv_quiet = $urandom_range(8, 30);
			end
			@(negedge clk);
			if (gap > 0) begin
				rsp_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ready = 1'b1;
			do @(posedge clk); while (!rsp_valid);
			sb.check_result(rsp_data);
			results_seen++;
		end
	end

	initial begin
		logic [47:0] cur_now;
		int counted;
		int sel;
		logic [6:0] ops;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Poll an empty table, then send an unused opcode
		send_req(make_req(OP_BUDGET, 48'd0, 32'd0, 16'd0, 7'd0, 1'b0));
		send_req(make_req(OP_ALL, 48'd0, 32'd0, 16'd0, 7'd0, 1'b0));
		send_req(make_req(OP_UNUSED, rand_time(), $urandom, 16'hFFFF, 7'd127, 1'b1));

		// Saturate the due time of a task with the largest period
		send_req(make_req(OP_REG, 48'd0, 32'hFFFF_FFFF, 16'd0, 7'd0, 1'b0));
		send_req(make_req(OP_BUDGET, TIME_MAX - 48'd3, 32'd0, 16'd0, 7'd1, 1'b1));

		// Zero-period task with the largest key, plus two tasks with a tied key
		send_req(make_req(OP_REG, 48'd100, 32'd0, 16'hFFFF, 7'd0, 1'b0));
		send_req(make_req(OP_REG, 48'd100, 32'd10, 16'd5, 7'd0, 1'b0));
		send_req(make_req(OP_REG, 48'd100, 32'd10, 16'd5, 7'd0, 1'b0));
		send_req(make_req(OP_BUDGET, 48'd100, 32'd0, 16'd0, 7'd5, 1'b1));

		// Budget beyond the cap, and the cap itself, on a repeating task
		send_req(make_req(OP_BUDGET, 48'd100, 32'd0, 16'd0, 7'd127, 1'b0));
		send_req(make_req(OP_BUDGET, 48'd100, 32'd0, 16'd0, 7'd64, 1'b1));
		send_req(make_req(OP_ALL, 48'd105, 32'd0, 16'd0, 7'd0, 1'b0));
		send_req(make_req(OP_ALL, 48'd110, 32'd0, 16'd0, 7'd0, 1'b0));

		// Run the saturated task at the top of the time range
		send_req(make_req(OP_BUDGET, TIME_MAX, 32'd0, 16'd0, 7'd2, 1'b0));

		// Fill the table, then overflow it
		for (int s = 4; s < TASK_SLOTS; s++)
			send_req(make_req(OP_REG, 48'd120, $urandom_range(1, 60),
				16'($urandom_range(0, 7)), 7'($urandom_range(0, 127)),
				1'($urandom_range(0, 1))));
		send_req(make_req(OP_REG, 48'd130, $urandom, 16'($urandom_range(0, 65535)), 7'd0,
			1'b0));

		// Random polls over a mostly forward-moving clock
		cur_now = 48'd200;
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			if ($urandom_range(0, 19) == 0)
				send_req(make_req(OP_UNUSED, rand_time(), $urandom,
					16'($urandom_range(0, 65535)), 7'($urandom_range(0, 127)),
					1'($urandom_range(0, 1))));
			if ($urandom_range(0, 19) == 0 && cur_now > 48'd60)
				cur_now = cur_now - 48'($urandom_range(1, 60));
			else
				cur_now = cur_now + 48'($urandom_range(0, 25));
			ops = ($urandom_range(0, 6) == 0) ? 7'($urandom_range(0, 127)) :
				7'($urandom_range(0, 8));
			sel = $urandom_range(0, 99);
			if (sel < 5)
				send_req(make_req(OP_REG, cur_now, $urandom, 16'($urandom_range(0, 65535)),
					ops, 1'($urandom_range(0, 1))));
			else if (sel < 52)
				send_req(make_req(OP_ALL, cur_now, $urandom, 16'($urandom_range(0, 65535)),
					ops, 1'($urandom_range(0, 1))));
			else
				send_req(make_req(OP_BUDGET, cur_now, $urandom, 16'($urandom_range(0, 65535)),
					ops, 1'($urandom_range(0, 1))));
			counted++;
		end
		@(negedge clk);
		req_valid = 1'b0;

		// Drain outstanding results, then watch for strays
		while (sb.outcome_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
